@@ rtl/fdsb_pkg.sv @@
// shared types, widths and constants of the frame detail score block
package fdsb_pkg;

  // frame geometry defaults
  localparam int MAX_FRAME_WIDTH_DEF  = 4096;
  localparam int MAX_FRAME_HEIGHT_DEF = 4096;
  localparam int SAMPLE_STEP_DEF      = 4;
  localparam int FRAME_WIDTH_RST      = 1920;
  localparam int FRAME_HEIGHT_RST     = 1080;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // stream fields
  localparam int LUMA_W      = 8;
  localparam int TAG_W       = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  // accumulator widths
  localparam int N_W = 21;
  localparam int S_W = 28;
  localparam int Q_W = 36;

  // scoring datapath widths
  localparam int SCORE_W = 22;
  localparam int V_W     = 57;
  localparam int F_W     = 29;
  localparam int D_W     = 63;
  localparam int MP_W    = 29;
  localparam int ALU_W   = 86;
  localparam int CNT_W   = 5;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [CNT_W-1:0]   MUL_LAST  = CNT_W'(MP_W - 1);
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(SCORE_W - 1);

  // finished frame sums handed to the scoring unit
  typedef struct packed {
    logic [N_W-1:0] total;
    logic [S_W-1:0] sum;
    logic [Q_W-1:0] sq;
  } acc_sums_t;

  // scoring unit result
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
  } score_res_t;

endpackage

@@ rtl/fdsb_alu.sv @@
// shared add/subtract unit of the scoring sequencer
module fdsb_alu (
  input  logic [fdsb_pkg::ALU_W-1:0] a,
  input  logic [fdsb_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [fdsb_pkg::ALU_W-1:0] res,
  output logic                       carry
);

  logic [fdsb_pkg::ALU_W:0] full;
  logic [fdsb_pkg::ALU_W-1:0] b_op;

  // on subtract carry out means a >= b
  assign b_op  = sub ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_op} + {{fdsb_pkg::ALU_W{1'b0}}, sub};
  assign res   = full[fdsb_pkg::ALU_W-1:0];
  assign carry = full[fdsb_pkg::ALU_W];

endmodule

@@ rtl/fdsb_accum.sv @@
// raster position tracking, sample selection and per-frame sums
module fdsb_accum #(
  parameter int MAX_FRAME_WIDTH  = fdsb_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = fdsb_pkg::MAX_FRAME_HEIGHT_DEF,
  parameter int SAMPLE_STEP      = fdsb_pkg::SAMPLE_STEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fdsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pix_take,
  input  logic [fdsb_pkg::LUMA_W-1:0]     luma,
  output logic                            frame_end,
  output logic                            at_first,
  output fdsb_pkg::acc_sums_t             fin
);

  localparam int COL_W = $clog2(MAX_FRAME_WIDTH);
  localparam int ROW_W = $clog2(MAX_FRAME_HEIGHT);
  localparam int PH_W  = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam int W_RST = (fdsb_pkg::FRAME_WIDTH_RST > MAX_FRAME_WIDTH) ?
                         MAX_FRAME_WIDTH : fdsb_pkg::FRAME_WIDTH_RST;
  localparam int H_RST = (fdsb_pkg::FRAME_HEIGHT_RST > MAX_FRAME_HEIGHT) ?
                         MAX_FRAME_HEIGHT : fdsb_pkg::FRAME_HEIGHT_RST;
  localparam logic [COL_W-1:0] COL_LAST_RST = COL_W'(W_RST - 1);
  localparam logic [ROW_W-1:0] ROW_LAST_RST = ROW_W'(H_RST - 1);
  localparam logic [COL_W-1:0] COL_LAST_MAX = COL_W'(MAX_FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST_MAX = ROW_W'(MAX_FRAME_HEIGHT - 1);
  localparam logic [PH_W-1:0]  PH_LAST      = PH_W'(SAMPLE_STEP - 1);

  logic [COL_W-1:0] col_last_r, col_last_nxt;
  logic [ROW_W-1:0] row_last_r, row_last_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PH_W-1:0]  col_ph_r, col_ph_nxt;
  logic [PH_W-1:0]  row_ph_r, row_ph_nxt;
  logic [fdsb_pkg::N_W-1:0] total_r, total_nxt;
  logic [fdsb_pkg::S_W-1:0] sum_r, sum_nxt;
  logic [fdsb_pkg::Q_W-1:0] sq_r, sq_nxt;
  logic       row_end;
  logic       sampled;
  logic [2*fdsb_pkg::LUMA_W-1:0] luma_sq;

  // clamp written geometry and keep the last column and row index
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_we) begin
      unique case (cfg_index)
        fdsb_pkg::CFG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            col_last_nxt = '0;
          end else if (32'(cfg_data) > MAX_FRAME_WIDTH) begin
            col_last_nxt = COL_LAST_MAX;
          end else begin
            col_last_nxt = COL_W'(cfg_data - 13'd1);
          end
        end
        fdsb_pkg::CFG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            row_last_nxt = '0;
          end else if (32'(cfg_data) > MAX_FRAME_HEIGHT) begin
            row_last_nxt = ROW_LAST_MAX;
          end else begin
            row_last_nxt = ROW_W'(cfg_data - 13'd1);
          end
        end
      endcase
    end
  end

  // raster end flags
  assign row_end   = (col_r >= col_last_r);
  assign frame_end = row_end && (row_r >= row_last_r);
  assign at_first  = (col_r == '0) && (row_r == '0);
  assign sampled   = (col_ph_r == '0) && (row_ph_r == '0);

  // sums including the current pixel
  assign luma_sq   = luma * luma;
  assign fin.total = total_r + fdsb_pkg::N_W'(sampled);
  assign fin.sum   = sum_r + (sampled ? fdsb_pkg::S_W'(luma) : '0);
  assign fin.sq    = sq_r + (sampled ? fdsb_pkg::Q_W'(luma_sq) : '0);

  // position and sum update per accepted pixel
  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    col_ph_nxt = col_ph_r;
    row_ph_nxt = row_ph_r;
    total_nxt  = total_r;
    sum_nxt    = sum_r;
    sq_nxt     = sq_r;
    if (pix_take) begin
      priority if (frame_end) begin
        col_nxt    = '0;
        row_nxt    = '0;
        col_ph_nxt = '0;
        row_ph_nxt = '0;
        total_nxt  = '0;
        sum_nxt    = '0;
        sq_nxt     = '0;
      end else if (row_end) begin
        col_nxt    = '0;
        row_nxt    = row_r + 1'b1;
        col_ph_nxt = '0;
        row_ph_nxt = (row_ph_r == PH_LAST) ? '0 : row_ph_r + 1'b1;
        total_nxt  = fin.total;
        sum_nxt    = fin.sum;
        sq_nxt     = fin.sq;
      end else begin
        col_nxt    = col_r + 1'b1;
        col_ph_nxt = (col_ph_r == PH_LAST) ? '0 : col_ph_r + 1'b1;
        total_nxt  = fin.total;
        sum_nxt    = fin.sum;
        sq_nxt     = fin.sq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= COL_LAST_RST;
      row_last_r <= ROW_LAST_RST;
      col_r      <= '0;
      row_r      <= '0;
      col_ph_r   <= '0;
      row_ph_r   <= '0;
      total_r    <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      col_ph_r   <= col_ph_nxt;
      row_ph_r   <= row_ph_nxt;
      total_r    <= total_nxt;
      sum_r      <= sum_nxt;
      sq_r       <= sq_nxt;
    end
  end

endmodule

@@ rtl/fdsb_score.sv @@
// frame score sequencer: shift-add products and restoring division on one adder
module fdsb_score (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  fdsb_pkg::acc_sums_t  fin,
  output logic                 busy,
  output fdsb_pkg::score_res_t res
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MUL_NQ  = 4'd1;
  localparam logic [3:0] ST_MUL_SS  = 4'd2;
  localparam logic [3:0] ST_SUB_V   = 4'd3;
  localparam logic [3:0] ST_DEV     = 4'd4;
  localparam logic [3:0] ST_F       = 4'd5;
  localparam logic [3:0] ST_MUL_NN  = 4'd6;
  localparam logic [3:0] ST_MUL_NNN = 4'd7;
  localparam logic [3:0] ST_MUL_VF  = 4'd8;
  localparam logic [3:0] ST_SAT     = 4'd9;
  localparam logic [3:0] ST_DIV     = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [fdsb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fdsb_pkg::N_W-1:0]   n_r, n_nxt;
  logic [fdsb_pkg::S_W-1:0]   s_r, s_nxt;
  logic [fdsb_pkg::V_W-1:0]   nq_r, nq_nxt;
  logic [fdsb_pkg::V_W-1:0]   v_r, v_nxt;
  logic [fdsb_pkg::F_W-1:0]   f_r, f_nxt;
  logic [fdsb_pkg::D_W-1:0]   d_r, d_nxt;
  logic                       ge_r, ge_nxt;
  logic [fdsb_pkg::ALU_W-1:0] acc_r, acc_nxt;
  logic [fdsb_pkg::ALU_W-1:0] mc_r, mc_nxt;
  logic [fdsb_pkg::MP_W-1:0]  mp_r, mp_nxt;
  logic [fdsb_pkg::SCORE_W-1:0] score_r, score_nxt;

  logic [fdsb_pkg::ALU_W-1:0] alu_a, alu_b, alu_res, mul_res;
  logic                       alu_sub, alu_co, mul_last;

  // operand select for the shared adder
  always_comb begin
    alu_a   = acc_r;
    alu_b   = mc_r;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_SUB_V: begin
        alu_a   = fdsb_pkg::ALU_W'(nq_r);
        alu_b   = acc_r;
        alu_sub = 1'b1;
      end
      ST_DEV: begin
        alu_a   = fdsb_pkg::ALU_W'(s_r);
        alu_b   = fdsb_pkg::ALU_W'(n_r) << 7;
        alu_sub = 1'b1;
      end
      ST_F: begin
        if (ge_r) begin
          alu_a   = fdsb_pkg::ALU_W'(n_r) << 8;
          alu_b   = acc_r;
          alu_sub = 1'b1;
        end else begin
          alu_a   = fdsb_pkg::ALU_W'(n_r) << 7;
          alu_b   = fdsb_pkg::ALU_W'(s_r);
        end
      end
      ST_SAT: begin
        alu_b   = fdsb_pkg::ALU_W'(d_r) << fdsb_pkg::SCORE_W;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  fdsb_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_co)
  );

  // one multiplier bit per cycle
  assign mul_res  = mp_r[0] ? alu_res : acc_r;
  assign mul_last = (cnt_r == fdsb_pkg::MUL_LAST);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    nq_nxt    = nq_r;
    v_nxt     = v_r;
    f_nxt     = f_r;
    d_nxt     = d_r;
    ge_nxt    = ge_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    mp_nxt    = mp_r;
    score_nxt = score_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt   = fin.total;
          s_nxt   = fin.sum;
          acc_nxt = '0;
          mc_nxt  = fdsb_pkg::ALU_W'(fin.sq);
          mp_nxt  = fdsb_pkg::MP_W'(fin.total);
          cnt_nxt = '0;
          if (fin.total == '0) begin
            score_nxt = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL_NQ;
          end
        end
      end
      ST_MUL_NQ, ST_MUL_SS, ST_MUL_NN, ST_MUL_NNN, ST_MUL_VF: begin
        acc_nxt = mul_res;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (mul_last) begin
          cnt_nxt = '0;
          unique case (state_r)
            ST_MUL_NQ: begin
              nq_nxt    = mul_res[fdsb_pkg::V_W-1:0];
              acc_nxt   = '0;
              mc_nxt    = fdsb_pkg::ALU_W'(s_r);
              mp_nxt    = fdsb_pkg::MP_W'(s_r);
              state_nxt = ST_MUL_SS;
            end
            ST_MUL_SS: begin
              state_nxt = ST_SUB_V;
            end
            ST_MUL_NN: begin
              acc_nxt   = '0;
              mc_nxt    = mul_res;
              mp_nxt    = fdsb_pkg::MP_W'(n_r);
              state_nxt = ST_MUL_NNN;
            end
            ST_MUL_NNN: begin
              d_nxt     = mul_res[fdsb_pkg::D_W-1:0];
              acc_nxt   = '0;
              mc_nxt    = fdsb_pkg::ALU_W'(v_r);
              mp_nxt    = f_r;
              state_nxt = ST_MUL_VF;
            end
            default: begin
              state_nxt = ST_SAT;
            end
          endcase
        end
      end
      // variance term, clipped at zero
      ST_SUB_V: begin
        v_nxt     = alu_co ? alu_res[fdsb_pkg::V_W-1:0] : '0;
        state_nxt = ST_DEV;
      end
      // sign of the mean offset
      ST_DEV: begin
        ge_nxt    = alu_co;
        acc_nxt   = alu_res;
        state_nxt = ST_F;
      end
      // brightness factor 256n - |S - 128n|, clipped at zero
      ST_F: begin
        if (ge_r) begin
          f_nxt = alu_co ? alu_res[fdsb_pkg::F_W-1:0] : '0;
        end else begin
          f_nxt = alu_res[fdsb_pkg::F_W-1:0];
        end
        acc_nxt   = '0;
        mc_nxt    = fdsb_pkg::ALU_W'(n_r);
        mp_nxt    = fdsb_pkg::MP_W'(n_r);
        cnt_nxt   = '0;
        state_nxt = ST_MUL_NN;
      end
      // quotient overflow check
      ST_SAT: begin
        if (alu_co) begin
          score_nxt = fdsb_pkg::SCORE_MAX;
          state_nxt = ST_DONE;
        end else begin
          mc_nxt    = fdsb_pkg::ALU_W'(d_r) << (fdsb_pkg::SCORE_W - 1);
          mp_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        if (alu_co) begin
          acc_nxt = alu_res;
        end
        mp_nxt  = {mp_r[fdsb_pkg::MP_W-2:0], alu_co};
        mc_nxt  = mc_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fdsb_pkg::DIV_LAST) begin
          score_nxt = {mp_r[fdsb_pkg::SCORE_W-2:0], alu_co};
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign res.valid = (state_r == ST_DONE);
  assign res.score = score_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    nq_r    <= nq_nxt;
    v_r     <= v_nxt;
    f_r     <= f_nxt;
    d_r     <= d_nxt;
    ge_r    <= ge_nxt;
    acc_r   <= acc_nxt;
    mc_r    <= mc_nxt;
    mp_r    <= mp_nxt;
    score_r <= score_nxt;
  end

endmodule

@@ rtl/frame_detail_score_best_select.sv @@
// top level: luma detail score per frame and best-frame record
//
// Pixels arrive in raster order and are taken one per cycle while in_tready
// is high. Every SAMPLE_STEP-th column of every SAMPLE_STEP-th row is summed.
// The frame's last pixel starts the scoring sequencer, which runs all its
// products and the final division through one shared 86-bit adder: five
// shift-add products, three add/subtract steps, an overflow check, a
// restoring division and a hand-over state. A frame with no sampled pixel
// skips the steps and scores zero. in_tready stays low while the sequencer is
// busy, and also while the previous result is still held in the output
// register and the next pixel would end a frame. One result goes out per
// frame, carrying the frame score, its tag and the best score since the
// last search start with the first frame tag that reached it. Configuration
// writes are always taken (cfg_ready is high).
module frame_detail_score_best_select #(
  parameter int MAX_FRAME_WIDTH  = fdsb_pkg::MAX_FRAME_WIDTH_DEF,
  parameter int MAX_FRAME_HEIGHT = fdsb_pkg::MAX_FRAME_HEIGHT_DEF,
  parameter int SAMPLE_STEP      = fdsb_pkg::SAMPLE_STEP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdsb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fdsb_pkg::IN_TDATA_W-1:0]   in_tdata,  // luma[7:0], frame_tag[15:8]
  input  logic [0:0]                        in_tuser,  // start_search[0]
  // score stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fdsb_pkg::OUT_TDATA_W-1:0]  out_tdata  // frame_score[21:0],
                                                       // scored_tag[29:22],
                                                       // best_score[51:30],
                                                       // best_tag[59:52], zero[63:60]
);

  logic                          pix_take;
  logic                          frame_end;
  logic                          at_first;
  logic                          score_busy;
  fdsb_pkg::acc_sums_t           fin;
  fdsb_pkg::score_res_t          res;
  logic [fdsb_pkg::LUMA_W-1:0]   luma;
  logic [fdsb_pkg::TAG_W-1:0]    tag;
  logic                          start_search;

  logic                          best_present_r, best_present_nxt;
  logic [fdsb_pkg::SCORE_W-1:0]  best_value_r, best_value_nxt;
  logic [fdsb_pkg::TAG_W-1:0]    best_frame_r, best_frame_nxt;
  logic [fdsb_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [fdsb_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                          best_upd;
  logic [fdsb_pkg::SCORE_W-1:0]  new_best_value;
  logic [fdsb_pkg::TAG_W-1:0]    new_best_frame;

  // input unpacking
  assign luma         = in_tdata[fdsb_pkg::LUMA_W-1:0];
  assign tag          = in_tdata[fdsb_pkg::LUMA_W +: fdsb_pkg::TAG_W];
  assign start_search = in_tuser[0];

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_tready = !score_busy && !(out_valid_r && frame_end);
  assign pix_take  = in_tvalid && in_tready;

  fdsb_accum #(
    .MAX_FRAME_WIDTH  (MAX_FRAME_WIDTH),
    .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT),
    .SAMPLE_STEP      (SAMPLE_STEP)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_take  (pix_take),
    .luma      (luma),
    .frame_end (frame_end),
    .at_first  (at_first),
    .fin       (fin)
  );

  fdsb_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pix_take && frame_end),
    .fin   (fin),
    .busy  (score_busy),
    .res   (res)
  );

  // best record, earlier frame kept on a tie
  assign best_upd       = !best_present_r || (res.score > best_value_r);
  assign new_best_value = best_upd ? res.score : best_value_r;
  assign new_best_frame = best_upd ? tag_r : best_frame_r;

  always_comb begin
    best_present_nxt = best_present_r;
    best_value_nxt   = best_value_r;
    best_frame_nxt   = best_frame_r;
    tag_nxt          = tag_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    // search start on a frame's first pixel
    if (pix_take && start_search && at_first) begin
      best_present_nxt = 1'b0;
      best_value_nxt   = '0;
      best_frame_nxt   = '0;
    end
    if (pix_take && frame_end) begin
      tag_nxt = tag;
    end
    // load the result register or retire a taken request
    priority if (res.valid) begin
      best_present_nxt = 1'b1;
      best_value_nxt   = new_best_value;
      best_frame_nxt   = new_best_frame;
      out_valid_nxt    = 1'b1;
      out_data_nxt     = {4'b0000, new_best_frame, new_best_value, tag_r, res.score};
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_present_r <= 1'b0;
      best_value_r   <= '0;
      best_frame_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      best_present_r <= best_present_nxt;
      best_value_r   <= best_value_nxt;
      best_frame_r   <= best_frame_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
